// ----- rtl/tkst_pkg.sv -----
package tkst_pkg;

  localparam int unsigned SCORE_W   = 32;
  localparam int unsigned TAG_W     = 64;
  localparam int unsigned RANK_W    = 4;
  localparam int unsigned FILL_W    = 4;
  localparam int unsigned S_TDATA_W = 104;
  localparam int unsigned M_TDATA_W = 104;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  typedef logic signed [SCORE_W-1:0] score_t;

  // broadcast to every cell
  typedef struct packed {
    logic   ins;
    score_t score;
  } cell_ctl_t;

  // handed from one cell to the next lower-ranked one
  typedef struct packed {
    logic   vld;
    logic   lt;
    score_t score;
  } cell_link_t;

endpackage

// ----- rtl/tkst_cell.sv -----
module tkst_cell #(
  parameter int unsigned TagBits = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tkst_pkg::cell_ctl_t   ctl_i,
  input  logic [TagBits-1:0]    new_tag_i,
  input  tkst_pkg::cell_link_t  prev_i,
  input  logic [TagBits-1:0]    prev_tag_i,
  output tkst_pkg::cell_link_t  link_o,
  output logic [TagBits-1:0]    tag_o
);
  import tkst_pkg::*;

  logic               vld_q;
  score_t             score_q;
  logic [TagBits-1:0] tag_q;
  logic               lt;

  // new score goes ahead of this entry (equal scores keep arrival order)
  assign lt = !vld_q || (score_q < ctl_i.score);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.ins) begin
      if (prev_i.lt) begin
        vld_q <= prev_i.vld;
      end else if (lt) begin
        vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ins) begin
      if (prev_i.lt) begin
        score_q <= prev_i.score;
        tag_q   <= prev_tag_i;
      end else if (lt) begin
        score_q <= ctl_i.score;
        tag_q   <= new_tag_i;
      end
    end
  end

  assign link_o.vld   = vld_q;
  assign link_o.lt    = lt;
  assign link_o.score = score_q;
  assign tag_o        = tag_q;

endmodule

// ----- rtl/top_k_score_tracker.sv -----
// the result of an accepted transaction appears on the master side in the next cycle
// throughput: one transaction per cycle while the master side keeps up; all cells compare in parallel and shift once
// the output register frees s_axis_tready whenever the result is taken or absent
// reset clears the cell valid bits, the fill count and the output valid
// stored scores and tags are not cleared; an empty cell is never read
module top_k_score_tracker #(
  parameter int unsigned TOP_ENTRIES = 10,
  parameter int unsigned TAG_BITS    = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // score [31:0], name_tag [95:32], read_rank [99:96], zero pad [103:100]
  input  logic [tkst_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // op
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // entry_rank [3:0], entry_score [35:4], entry_tag [99:36], fill_count [103:100]
  output logic [tkst_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // entry_valid
  output logic                             m_axis_tuser
);
  import tkst_pkg::*;

  localparam int unsigned CntW = $clog2(TOP_ENTRIES + 1);
  localparam int unsigned CmpW = (CntW > RANK_W) ? CntW : RANK_W;

  // input transaction fields
  score_t              in_score;
  logic [TAG_W-1:0]    in_tag;
  logic [RANK_W-1:0]   in_rank;
  op_e                 in_op;
  logic [TAG_BITS-1:0] new_tag;

  assign in_score = s_axis_tdata[SCORE_W-1:0];
  assign in_tag   = s_axis_tdata[SCORE_W+TAG_W-1:SCORE_W];
  assign in_rank  = s_axis_tdata[SCORE_W+TAG_W+RANK_W-1:SCORE_W+TAG_W];
  assign in_op    = op_e'(s_axis_tuser);
  assign new_tag  = in_tag[TAG_BITS-1:0];

  logic accept;
  logic out_vld_q;

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // chain of cells, rank 0 at the head
  cell_ctl_t           ctl;
  cell_link_t          link [TOP_ENTRIES];
  logic [TAG_BITS-1:0] link_tag [TOP_ENTRIES];
  cell_link_t          head_link;
  logic [TOP_ENTRIES-1:0] lt_vec;
  logic [TOP_ENTRIES-1:0] vld_vec;

  assign ctl.ins   = accept && (in_op == OP_INSERT);
  assign ctl.score = in_score;

  assign head_link.vld   = 1'b0;
  assign head_link.lt    = 1'b0;
  assign head_link.score = '0;

  for (genvar g = 0; g < TOP_ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      tkst_cell #(.TagBits(TAG_BITS)) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctl_i      (ctl),
        .new_tag_i  (new_tag),
        .prev_i     (head_link),
        .prev_tag_i ('0),
        .link_o     (link[g]),
        .tag_o      (link_tag[g])
      );
    end else begin : g_body
      tkst_cell #(.TagBits(TAG_BITS)) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctl_i      (ctl),
        .new_tag_i  (new_tag),
        .prev_i     (link[g-1]),
        .prev_tag_i (link_tag[g-1]),
        .link_o     (link[g]),
        .tag_o      (link_tag[g])
      );
    end
    assign lt_vec[g]  = link[g].lt;
    assign vld_vec[g] = link[g].vld;
  end

  // insert position: the first cell whose entry the new score displaces;
  // lt is monotone down the chain, so the last cell tells if it fits at all
  logic              ins_fit;
  logic [CmpW-1:0]   ins_pos;

  assign ins_fit = lt_vec[TOP_ENTRIES-1];

  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < TOP_ENTRIES; i++) begin
      if (lt_vec[i] && (i == 0 || !lt_vec[(i == 0) ? 0 : i - 1])) begin
        ins_pos = ins_pos | CmpW'(i);
      end
    end
  end

  // fill count
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            full;

  assign full = (cnt_q == CntW'(TOP_ENTRIES));

  always_comb begin
    cnt_d = cnt_q;
    if (ctl.ins && ins_fit && !full) begin
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // read path: pick the cell at the requested rank
  logic [CmpW-1:0]     rd_rank;
  logic                rd_hit;
  score_t              rd_score;
  logic [TAG_BITS-1:0] rd_tag;

  assign rd_rank = CmpW'(in_rank);
  assign rd_hit  = rd_rank < CmpW'(cnt_q);

  always_comb begin
    rd_score = '0;
    rd_tag   = '0;
    for (int i = 0; i < TOP_ENTRIES; i++) begin
      if (rd_rank == CmpW'(i)) begin
        rd_score = rd_score | link[i].score;
        rd_tag   = rd_tag | link_tag[i];
      end
    end
  end

  // result for this transaction
  logic                res_valid;
  logic [RANK_W-1:0]   res_rank;
  score_t              res_score;
  logic [TAG_W-1:0]    res_tag;
  logic [CmpW-1:0]     res_fill;

  always_comb begin
    unique case (in_op)
      OP_INSERT: begin
        res_valid = ins_fit;
        res_rank  = ins_fit ? ins_pos[RANK_W-1:0] : '0;
        res_score = ins_fit ? in_score : '0;
        res_tag   = ins_fit ? TAG_W'(new_tag) : '0;
        res_fill  = CmpW'(cnt_d);
      end
      OP_READ: begin
        res_valid = rd_hit;
        res_rank  = in_rank;
        res_score = rd_hit ? rd_score : '0;
        res_tag   = rd_hit ? TAG_W'(rd_tag) : '0;
        res_fill  = CmpW'(cnt_q);
      end
      default: begin
        res_valid = 1'b0;
        res_rank  = '0;
        res_score = '0;
        res_tag   = '0;
        res_fill  = '0;
      end
    endcase
  end

  // output register
  logic [M_TDATA_W-1:0] out_data_q;
  logic                 out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {res_fill[FILL_W-1:0], res_tag, res_score, res_rank};
      out_user_q <= res_valid;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // kept entries always sit at the head of the chain
  a_vld_contiguous : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, vld_vec} + {{TOP_ENTRIES{1'b0}}, 1'b1}))
    else $error("cell valid bits not contiguous from rank zero");

  // fill count tracks the number of occupied cells
  a_cnt_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_vec) == int'(cnt_q))
    else $error("fill count differs from occupied cells");

  // an insert that fits shows up next cycle with its valid flag set
  a_ins_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.ins && ins_fit) |=> (m_axis_tvalid && m_axis_tuser))
    else $error("fitting insert lost its result");

  // a full list stays full
  a_full_sticks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |=> (cnt_q == CntW'(TOP_ENTRIES)))
    else $error("full list lost an entry");

endmodule

// ----- tb/tb_top_k_score_tracker.sv -----
`timescale 1ns / 1ps

module tb_top_k_score_tracker;
  import tkst_pkg::*;

  localparam int unsigned TOP_N    = 10;
  localparam int unsigned TAG_BITS = 64;

  // one transaction on the slave side, plus pacing hints for the driver
  typedef struct {
    op_e          op;
    score_t       score;
    logic [63:0]  tag;
    logic [3:0]   rank;
    int           gap;          // idle cycles before this item is offered
    bit           drain_first;  // hold until every result so far has come back
  } board_req_t;

  // one result transaction on the master side
  typedef struct {
    logic         valid;
    logic [3:0]   rank;
    score_t       score;
    logic [63:0]  tag;
    logic [3:0]   fill;
  } board_resp_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   m_axis_tuser;

  top_k_score_tracker #(
    .TOP_ENTRIES (TOP_N),
    .TAG_BITS    (TAG_BITS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // predicted leaderboard contents
  score_t       board_score [TOP_N];
  logic [63:0]  board_tag   [TOP_N];
  int unsigned  board_fill = 0;

  board_req_t   pending_items[$];
  board_resp_t  expected_results[$];

  int  err_count      = 0;
  int  results_seen   = 0;
  int  inserts_kept   = 0;
  int  inserts_dropped = 0;
  int  reads_hit      = 0;
  int  reads_past     = 0;
  bit  s_taken        = 1'b0;  // the offered item went in at the last rising edge

  // mostly short gaps, now and then a long one
  function automatic int draw_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return $urandom_range(1, 2);
    else if (pick < 90) return $urandom_range(3, 6);
    else return $urandom_range(10, 40);
  endfunction

  // apply one accepted item to the predicted board and return its result
  function automatic board_resp_t update_board(board_req_t req);
    board_resp_t res;
    int unsigned slot;
    int unsigned last;
    res = '{valid: 1'b0, rank: 4'd0, score: '0, tag: '0, fill: 4'd0};
    if (req.op == OP_INSERT) begin
      // stable insertion: land after every entry with an equal or higher score
      slot = 0;
      while (slot < board_fill && board_score[slot] >= req.score) slot++;
      if (slot < TOP_N) begin
        last = (board_fill < TOP_N) ? board_fill : TOP_N - 1;
        for (int unsigned i = last; i > slot; i--) begin
          board_score[i] = board_score[i-1];
          board_tag[i]   = board_tag[i-1];
        end
        board_score[slot] = req.score;
        board_tag[slot]   = req.tag;
        if (board_fill < TOP_N) board_fill++;
        res.valid = 1'b1;
        res.rank  = slot[3:0];
        res.score = req.score;
        res.tag   = req.tag;
      end
      // a score below a full board of equal or better ones leaves it untouched
    end else begin
      res.rank = req.rank;
      if (req.rank < board_fill) begin
        res.valid = 1'b1;
        res.score = board_score[req.rank];
        res.tag   = board_tag[req.rank];
      end
    end
    res.fill = board_fill[3:0];
    return res;
  endfunction

  task automatic compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (exp_val !== act_val) begin
      err_count++;
      $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
    end
  endtask

  task automatic queue_item(op_e op, score_t score, logic [63:0] tag, logic [3:0] rank,
                            int gap, bit drain_first);
    board_req_t req;
    req = '{op: op, score: score, tag: tag, rank: rank, gap: gap,
            drain_first: drain_first};
    pending_items.push_back(req);
  endtask

  // ---------------------------------------------------------------------------
  // monitor: results are checked before the new prediction goes in, so an item
  // taken at the same edge never pairs with the result leaving at that edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    board_resp_t exp_res;
    board_req_t  req;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          err_count++;
          $error("result transaction with no expectation pending: %h", m_axis_tdata);
        end else begin
          exp_res = expected_results.pop_front();
          compare_field("entry_valid", exp_res.valid, m_axis_tuser);
          compare_field("entry_rank", exp_res.rank, m_axis_tdata[3:0]);
          compare_field("entry_score", $unsigned(exp_res.score), m_axis_tdata[35:4]);
          compare_field("entry_tag", exp_res.tag, m_axis_tdata[99:36]);
          compare_field("fill_count", exp_res.fill, m_axis_tdata[103:100]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req.op    = op_e'(s_axis_tuser);
        req.score = s_axis_tdata[31:0];
        req.tag   = s_axis_tdata[95:32];
        req.rank  = s_axis_tdata[99:96];
        exp_res = update_board(req);
        expected_results.push_back(exp_res);
        if (req.op == OP_INSERT) begin
          if (exp_res.valid) inserts_kept++;
          else inserts_dropped++;
        end else begin
          if (exp_res.valid) reads_hit++;
          else reads_past++;
        end
      end
    end
    s_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

  // ---------------------------------------------------------------------------
  // driver: holds an item until it is taken, then honors the next gap or drain
  // ---------------------------------------------------------------------------
  int         src_wait  = 0;
  bit         src_armed = 1'b0;

  always @(negedge clk_i) begin
    board_req_t req;
    if (rst_ni && !(s_axis_tvalid && !s_taken)) begin
      if (!src_armed && pending_items.size() > 0) begin
        src_wait  = pending_items[0].gap;
        src_armed = 1'b1;
      end
      if (!src_armed || src_wait > 0) begin
        s_axis_tvalid <= 1'b0;
        if (src_wait > 0) src_wait--;
      end else if (pending_items[0].drain_first && expected_results.size() != 0) begin
        // sender pause: wait for the block to hand back everything it owes
        s_axis_tvalid <= 1'b0;
      end else begin
        req = pending_items.pop_front();
        src_armed = 1'b0;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req.op;
        s_axis_tdata  <= {4'b0000, req.rank, req.tag, req.score};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result sink: random stalls, calm stretches, and long hold-offs that let
  // the output register fill and back-pressure the sender
  // ---------------------------------------------------------------------------
  int  sink_stall    = 0;
  int  long_hold     = 0;
  int  next_hold_at  = 300;
  int  sink_cycle    = 0;
  bit  sink_calm     = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      sink_cycle++;
      if (sink_cycle % 300 == 0) sink_calm = ($urandom_range(0, 2) == 0);
      if (results_seen >= next_hold_at) begin
        long_hold    = 400;
        next_hold_at = next_hold_at + 900;
      end
      if (long_hold > 0) begin
        m_axis_tready <= 1'b0;
        long_hold--;
      end else if (sink_stall > 0) begin
        m_axis_tready <= 1'b0;
        sink_stall--;
      end else if (!sink_calm && $urandom_range(0, 99) < 25) begin
        m_axis_tready <= 1'b0;
        sink_stall = draw_gap() - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    longint      center;
    int          gap;
    bit          calm_block;
    score_t      score;
    logic [63:0] tag;
    int          pick;

    // directed: empty reads, extreme scores, ties, a full board and drops
    queue_item(OP_READ,   '0,            '0,          4'd0,  0, 1'b0);
    queue_item(OP_READ,   32'hFFFF_FFFF, '1,          4'd15, 0, 1'b0);
    queue_item(OP_INSERT, 32'h7FFF_FFFF, '1,          4'd0,  0, 1'b0);
    queue_item(OP_INSERT, 32'h8000_0000, '0,          4'd0,  0, 1'b0);
    queue_item(OP_INSERT, 32'd0,         64'hA,       4'd0,  0, 1'b0);
    queue_item(OP_INSERT, 32'd0,         64'hB,       4'd0,  1, 1'b0);  // tie lands after
    queue_item(OP_INSERT, 32'hFFFF_FFFF, 64'h5555_AAAA_5555_AAAA, 4'd0, 0, 1'b0);
    queue_item(OP_INSERT, 32'd1,         64'hAAAA_5555_AAAA_5555, 4'd0, 0, 1'b0);
    queue_item(OP_INSERT, 32'h7FFF_FFFF, 64'hC,       4'd0,  2, 1'b0);  // tie at the top
    queue_item(OP_INSERT, 32'd100,       64'h1234_5678_9ABC_DEF0, 4'd0, 0, 1'b0);
    queue_item(OP_INSERT, -32'sd100,     64'h0FED_CBA9_8765_4321, 4'd0, 0, 1'b0);
    queue_item(OP_INSERT, 32'h8000_0000, 64'hD,       4'd0,  0, 1'b0);  // fills the board
    queue_item(OP_INSERT, 32'h8000_0000, 64'hE,       4'd0,  0, 1'b0);  // does not fit
    queue_item(OP_INSERT, 32'h8000_0001, 64'hF,       4'd0,  0, 1'b0);  // bumps the last
    queue_item(OP_READ,   '0,            '0,          4'd0,  0, 1'b0);
    queue_item(OP_READ,   '0,            '0,          4'd9,  0, 1'b0);
    queue_item(OP_READ,   '0,            '0,          4'd10, 0, 1'b0);
    queue_item(OP_READ,   '0,            '0,          4'd15, 3, 1'b0);
    queue_item(OP_READ,   32'hFFFF_FFFF, '1,          4'd5,  0, 1'b0);
    queue_item(OP_INSERT, 32'd50,        '1,          4'd15, 0, 1'b0);

    // random: a drifting center keeps new scores landing across the whole
    // range, narrow spreads around it make ties, a few draws are wild
    center     = -64'sd2147483000;
    calm_block = 1'b0;
    for (int n = 0; n < 1830; n++) begin
      if (n % 150 == 0) calm_block = ($urandom_range(0, 2) == 0);
      center = center + $urandom_range(0, 4600000);
      if (center > 64'sd2147483000) center = 64'sd2147483000;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        case ($urandom_range(0, 3))
          0: score = 32'h8000_0000;
          1: score = 32'hFFFF_FFFF;
          2: score = 32'd0;
          default: score = 32'h7FFF_FFFE;
        endcase
      end else if (pick < 20) begin
        score = $urandom;
      end else if (pick < 60) begin
        score = score_t'(center + $urandom_range(0, 4) - 2);
      end else begin
        score = score_t'(center + $urandom_range(0, 400000) - 200000);
      end
      tag = {$urandom, $urandom};
      if ($urandom_range(0, 49) == 0) tag = $urandom_range(0, 1) ? '1 : '0;
      gap = 0;
      if (!calm_block && $urandom_range(0, 99) < 40) gap = draw_gap();
      queue_item(($urandom_range(0, 99) < 65) ? OP_INSERT : OP_READ, score, tag,
                 4'($urandom_range(0, 15)), gap, (n == 0) || (n == 900));
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_items.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    // a few extra edges catch any stray result
    repeat (10) @(posedge clk_i);

    $display("run covered %0d inserts (%0d kept, %0d dropped) and %0d reads",
             inserts_kept + inserts_dropped, inserts_kept, inserts_dropped,
             reads_hit + reads_past);
    $display("reads inside the fill: %0d, past the fill: %0d, results checked: %0d",
             reads_hit, reads_past, results_seen);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("tb_top_k_score_tracker passed");
    end else begin
      $display("tb_top_k_score_tracker failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("tb_top_k_score_tracker failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tkst_pkg.sv
rtl/tkst_cell.sv
rtl/top_k_score_tracker.sv
tb/tb_top_k_score_tracker.sv
